[rtl/core/bounded_list_insert_search_remove_top_assert.svh]
// Assertion macros for the bounded list core.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef BOUNDED_LIST_INSERT_SEARCH_REMOVE_TOP_ASSERT_SVH
`define BOUNDED_LIST_INSERT_SEARCH_REMOVE_TOP_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define BLISR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLISR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/blisr_pkg.sv]
// Shared constants and codes for the bounded list core.
// No dependencies.
`default_nettype none

package blisr_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [OpW-1:0] OpInsert = 2'd0;
  localparam logic [OpW-1:0] OpQuery  = 2'd1;
  localparam logic [OpW-1:0] OpRemove = 2'd2;

  // Any other mode code compares as greater.
  localparam logic [ModeW-1:0] ModeLess  = 2'd0;
  localparam logic [ModeW-1:0] ModeEqual = 2'd1;

  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusFull    = 2'd1;
  localparam logic [StatusW-1:0] StatusNoMatch = 2'd2;

endpackage

`default_nettype wire

[rtl/core/bounded_list_insert_search_remove_top.sv]
// Bounded front-insert list with search and remove, single module core.
// Depends on blisr_pkg and bounded_list_insert_search_remove_top_assert.svh.
//
//  channel   | dir | tdata (low bit up)                         | tuser
//  ----------+-----+--------------------------------------------+----------
//  s_axis    | in  | value[31:0] mode[33:32], zero to bit 39    | op[1:0]
//  m_axis    | out | found[0] status[2:1] count[7:3] is_empty[8] | -
//
// Insert, no-op and any walk of an empty list go straight to StDone, which
// loads the result register and returns to idle to take input again.
// Query and remove walk the entries from the front one per cycle through the
// single read port; a remove then moves every later entry one slot forward,
// one per cycle. A walk ends at a query hit or at the last stored entry.
// Reset clears control state, count and head pointer only, no clearing pass;
// a held result stalls only the hand-over of the next finished result.
`default_nettype none

`include "bounded_list_insert_search_remove_top_assert.svh"

module bounded_list_insert_search_remove_top #(
  parameter int unsigned DEPTH = blisr_pkg::DefaultDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // value[31:0], mode[33:32], zeros [39:34]
  input  wire logic [blisr_pkg::InDataW-1:0]  s_axis_tdata,
  // op[1:0]
  input  wire logic [blisr_pkg::OpW-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // found[0], status[2:1], count[7:3], is_empty[8], zeros [15:9]
  output logic [blisr_pkg::OutDataW-1:0]      m_axis_tdata
);
  import blisr_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam logic [AddrW-1:0] LastAddr  = AddrW'(DEPTH - 1);
  localparam logic [CntW-1:0]  FullCount = CntW'(DEPTH);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StShift = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  // Control state
  state_e              state_q, state_d;
  logic [AddrW-1:0]    head_q, head_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                m_valid_q, m_valid_d;

  // Payload state
  logic [OpW-1:0]      op_q, op_d;
  logic [ValueW-1:0]   value_q, value_d;
  logic [ModeW-1:0]    mode_q, mode_d;
  logic [AddrW-1:0]    scan_addr_q, scan_addr_d;
  logic [AddrW-1:0]    scan_idx_q, scan_idx_d;
  logic [AddrW-1:0]    dst_q, dst_d;
  logic                res_found_q, res_found_d;
  logic [StatusW-1:0]  res_status_q, res_status_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  // Entry memory, one write and one registered read port
  logic [ValueW-1:0]   mem_q [DEPTH];
  logic [ValueW-1:0]   rdata_q;
  logic                rd_en, wr_en;
  logic [AddrW-1:0]    rd_addr, wr_addr;
  logic [ValueW-1:0]   wr_data;

  logic                in_fire;
  logic [OpW-1:0]      in_op;
  logic [ValueW-1:0]   in_value;
  logic [ModeW-1:0]    in_mode;
  logic [AddrW-1:0]    scan_addr_nxt;
  logic [AddrW-1:0]    head_dec;
  logic                scan_last;
  logic                cmp_lt, cmp_eq, match;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_op         = s_axis_tuser;
  assign in_value      = s_axis_tdata[ValueW-1:0];
  assign in_mode       = s_axis_tdata[ValueW+ModeW-1:ValueW];

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Circular addressing: logical slot 0 is at head_q
  assign scan_addr_nxt = (scan_addr_q == LastAddr) ? '0 : scan_addr_q + AddrW'(1);
  assign head_dec      = (head_q == '0) ? LastAddr : head_q - AddrW'(1);
  assign scan_last     = ((CntW'(scan_idx_q) + CntW'(1)) == count_q);

  // Shared compare unit: entry from memory against the latched operand
  assign cmp_lt = $signed(rdata_q) < $signed(value_q);
  assign cmp_eq = (rdata_q == value_q);

  always_comb begin
    if (op_q == OpQuery) begin
      match = cmp_eq;
    end else begin
      case (mode_q)
        ModeLess:  match = cmp_lt;
        ModeEqual: match = cmp_eq;
        default:   match = !cmp_lt && !cmp_eq;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    m_valid_d    = m_valid_q;
    op_d         = op_q;
    value_d      = value_q;
    mode_d       = mode_q;
    scan_addr_d  = scan_addr_q;
    scan_idx_d   = scan_idx_q;
    dst_d        = dst_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    m_data_d     = m_data_q;
    rd_en        = 1'b0;
    rd_addr      = scan_addr_nxt;
    wr_en        = 1'b0;
    wr_addr      = dst_q;
    wr_data      = rdata_q;

    // Drop the held result once the sink takes it
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          op_d         = in_op;
          value_d      = in_value;
          mode_d       = in_mode;
          res_found_d  = 1'b0;
          res_status_d = StatusOk;
          state_d      = StDone;
          case (in_op)
            OpInsert: begin
              if (count_q == FullCount) begin
                res_status_d = StatusFull;
              end else begin
                wr_en   = 1'b1;
                wr_addr = head_dec;
                wr_data = in_value;
                head_d  = head_dec;
                count_d = count_q + CntW'(1);
              end
            end
            OpQuery, OpRemove: begin
              if (count_q == '0) begin
                res_status_d = (in_op == OpRemove) ? StatusNoMatch : StatusOk;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = head_q;
                scan_addr_d = head_q;
                scan_idx_d  = '0;
                state_d     = StScan;
              end
            end
            default: ;
          endcase
        end
      end

      StScan: begin
        if (match) begin
          res_found_d = 1'b1;
          if (op_q == OpQuery) begin
            state_d = StDone;
          end else if (scan_last) begin
            // Hit on the last entry: nothing behind it to move
            count_d = count_q - CntW'(1);
            state_d = StDone;
          end else begin
            dst_d       = scan_addr_q;
            rd_en       = 1'b1;
            scan_addr_d = scan_addr_nxt;
            scan_idx_d  = scan_idx_q + AddrW'(1);
            state_d     = StShift;
          end
        end else if (scan_last) begin
          res_status_d = (op_q == OpRemove) ? StatusNoMatch : StatusOk;
          state_d      = StDone;
        end else begin
          rd_en       = 1'b1;
          scan_addr_d = scan_addr_nxt;
          scan_idx_d  = scan_idx_q + AddrW'(1);
        end
      end

      StShift: begin
        // Move the entry just read one slot toward the front
        wr_en = 1'b1;
        if (scan_last) begin
          count_d = count_q - CntW'(1);
          state_d = StDone;
        end else begin
          dst_d       = scan_addr_q;
          rd_en       = 1'b1;
          scan_addr_d = scan_addr_nxt;
          scan_idx_d  = scan_idx_q + AddrW'(1);
        end
      end

      StDone: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          m_data_d[0]   = res_found_q;
          m_data_d[2:1] = res_status_q;
          m_data_d[7:3] = CountW'(count_q);
          m_data_d[8]   = (count_q == '0);
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    value_q      <= value_d;
    mode_q       <= mode_d;
    scan_addr_q  <= scan_addr_d;
    scan_idx_q   <= scan_idx_d;
    dst_q        <= dst_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  `BLISR_ASSERT(a_count_bound, count_q <= FullCount, "entry count above depth")
  `BLISR_ASSERT_NEXT(a_insert_grows,
    in_fire && (in_op == OpInsert) && (count_q != FullCount),
    count_q == ($past(count_q) + CntW'(1)), "insert did not grow the count")
  `BLISR_ASSERT(a_walk_in_range,
    !((state_q == StScan) || (state_q == StShift)) || (CntW'(scan_idx_q) < count_q),
    "walk index beyond stored entries")
  `BLISR_ASSERT(a_shift_only_remove, (state_q != StShift) || (op_q == OpRemove),
    "entry move outside a remove")
  `BLISR_ASSERT(a_result_from_done, !$rose(m_valid_q) || $past(state_q == StDone),
    "result presented without a finished operation")

endmodule

`default_nettype wire
